// ===== hw/rtl/slid_pkg.sv =====
// Package for the sorted list block: operation and status codes, cell control type.
// No dependencies; imported by slid_cell, sorted_list_insert_delete, slid_checker and tb.
package slid_pkg;

  // Field widths fixed by the stream payload
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned PVALUE_W = 16;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned ECOUNT_W = 5;

  // Operation codes (in_tuser)
  localparam logic [FUNC_W-1:0] OP_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] OP_DELETE = 2'd1;
  localparam logic [FUNC_W-1:0] OP_CLEAR  = 2'd2;
  localparam logic [FUNC_W-1:0] OP_READ   = 2'd3;

  // Status codes (out_tuser)
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd5;
  localparam logic [STATUS_W-1:0] ST_READ_OK   = 3'd6;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd7;

  // Broadcast control from the top level to every cell
  typedef struct packed {
    logic ins_en;  // shift right from the insert point, drop value in
    logic del_en;  // shift left over the first matching entry
  } slid_cell_ctrl_t;

endpackage

// ===== hw/rtl/slid_cell.sv =====
// One cell of the sorted list chain: holds one entry, compares it with the broadcast value.
// Depends on slid_pkg; instantiated once per list position by sorted_list_insert_delete.
module slid_cell
  import slid_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic                   clk,
  input  slid_cell_ctrl_t        ctrl,
  input  logic [VALUE_WIDTH-1:0] val,         // broadcast operand
  input  logic                   valid,       // position is below the entry count
  input  logic                   prev_lt,     // left neighbor holds a smaller value
  input  logic [VALUE_WIDTH-1:0] prev_entry,  // left neighbor's entry
  input  logic [VALUE_WIDTH-1:0] next_entry,  // right neighbor's entry
  output logic [VALUE_WIDTH-1:0] entry,
  output logic                   lt,
  output logic                   eq
);

  logic [VALUE_WIDTH-1:0] entry_r;
  logic [VALUE_WIDTH-1:0] entry_nxt;

  // Compare against the broadcast operand
  assign lt    = valid && ($signed(entry_r) < $signed(val));
  assign eq    = valid && (entry_r == val);
  assign entry = entry_r;

  // Insert: cells at or past the insert point take from the left; the first one takes val.
  // Delete: cells at or past the first match take from the right.
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.ins_en && !lt) begin
      entry_nxt = prev_lt ? val : prev_entry;
    end else if (ctrl.del_en && !lt) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ===== hw/rtl/sorted_list_insert_delete.sv =====
// Sorted list of signed values: top level with stream ports, count and result register.
// Depends on slid_pkg and slid_cell.
//
// The list is a row of CAPACITY cells, each holding one entry in ascending order. An
// operation is broadcast to all cells at once: every cell compares its entry with the
// value, and on insert or delete each cell either keeps its entry or takes its left or
// right neighbor's, so the whole list shifts in the same clock. One transfer can be taken
// every clock; its result is on the output register in the next cycle, and a new transfer
// is taken while that result waits as long as out_tready is high. The longest path is the
// signed compare in each cell, the OR of the match flags across the row (delete), and the
// shift select back into the cells. Entries only become meaningful once written; the
// entry count alone marks which cells hold data, so no clearing pass follows reset.
module sorted_list_insert_delete
  import slid_pkg::*;
#(
  parameter int unsigned CAPACITY    = 16,
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Operation channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [15:0] value, [19:16] position, [23:20] zero
  input  logic [1:0]  in_tuser,   // [1:0] func
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [15:0] read_value, [20:16] entry_count, [23:21] zero
  output logic [2:0]  out_tuser   // [2:0] status
);

  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned PCW  = (CW > POS_W) ? CW : POS_W;
  localparam int unsigned RD_N = (CAPACITY < 16) ? CAPACITY : 16;

  // Input fields
  logic [FUNC_W-1:0]      in_func;
  logic [PVALUE_W-1:0]    in_value;
  logic [POS_W-1:0]       in_position;
  logic [VALUE_WIDTH-1:0] op_val;
  logic                   in_fire;

  assign in_func     = in_tuser;
  assign in_value    = in_tdata[15:0];
  assign in_position = in_tdata[19:16];
  assign in_fire     = in_tvalid && in_tready;

  // Take the value as a VALUE_WIDTH-bit pattern
  generate
    if (VALUE_WIDTH <= PVALUE_W) begin : g_val_narrow
      assign op_val = in_value[VALUE_WIDTH-1:0];
    end else begin : g_val_wide
      assign op_val = VALUE_WIDTH'(in_value);
    end
  endgenerate

  // Control state and result register
  logic [CW-1:0]       count_r, count_nxt;
  logic                out_valid_r;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [PVALUE_W-1:0] rdval_r, rdval_nxt;
  logic [ECOUNT_W-1:0] ecount_r;

  // Cell row
  logic [VALUE_WIDTH-1:0] entry_w [CAPACITY];
  logic [CAPACITY-1:0]    lt_w;
  logic [CAPACITY-1:0]    eq_w;
  logic [CAPACITY-1:0]    vld_w;
  slid_cell_ctrl_t        ctrl;

  logic found;
  logic full;

  assign found = |eq_w;
  assign full  = (count_r == CW'(CAPACITY));

  assign ctrl.ins_en = in_fire && (in_func == OP_INSERT) && !full;
  assign ctrl.del_en = in_fire && (in_func == OP_DELETE) && found;

  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                   prev_lt;
      logic [VALUE_WIDTH-1:0] prev_entry;
      logic [VALUE_WIDTH-1:0] next_entry;

      assign vld_w[i] = (CW'(i) < count_r);

      if (i == 0) begin : g_first
        assign prev_lt    = 1'b1;
        assign prev_entry = entry_w[i];
      end else begin : g_mid
        assign prev_lt    = lt_w[i-1];
        assign prev_entry = entry_w[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
        assign next_entry = entry_w[i];
      end else begin : g_inner
        assign next_entry = entry_w[i+1];
      end

      slid_cell #(
        .VALUE_WIDTH(VALUE_WIDTH)
      ) u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .val       (op_val),
        .valid     (vld_w[i]),
        .prev_lt   (prev_lt),
        .prev_entry(prev_entry),
        .next_entry(next_entry),
        .entry     (entry_w[i]),
        .lt        (lt_w[i]),
        .eq        (eq_w[i])
      );
    end
  endgenerate

  // Read select over the positions the 4-bit field can reach
  logic [VALUE_WIDTH-1:0] rd_sel;
  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < RD_N; i++) begin
      if (in_position == POS_W'(i)) begin
        rd_sel = entry_w[i];
      end
    end
  end

  // Status and next count
  always_comb begin
    count_nxt  = count_r;
    rdval_nxt  = '0;
    status_nxt = ST_RANGE;
    unique case (in_func)
      OP_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt = ST_INSERTED;
          count_nxt  = count_r + 1'b1;
        end
      end
      OP_DELETE: begin
        if (count_r == '0) begin
          status_nxt = ST_EMPTY;
        end else if (!found) begin
          status_nxt = ST_NOT_FOUND;
        end else begin
          status_nxt = ST_DELETED;
          count_nxt  = count_r - 1'b1;
        end
      end
      OP_CLEAR: begin
        status_nxt = ST_CLEARED;
        count_nxt  = '0;
      end
      OP_READ: begin
        if (PCW'(in_position) < PCW'(count_r)) begin
          status_nxt = ST_READ_OK;
          rdval_nxt  = PVALUE_W'(rd_sel);
        end else begin
          status_nxt = ST_RANGE;
        end
      end
      default: begin
        status_nxt = ST_RANGE;
      end
    endcase
  end

  // Output register doubles as the skid stage
  assign in_tready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_r <= status_nxt;
      rdval_r  <= rdval_nxt;
      ecount_r <= ECOUNT_W'(count_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {3'b000, ecount_r, rdval_r};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_func == OP_INSERT) && !full) |=> (count_r == CW'($past(count_r) + 1'b1)))
    else $error("insert did not grow the count");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_func == OP_CLEAR)) |=> (count_r == '0))
    else $error("clear left entries");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (out_tvalid && (out_tdata[20:16] == ECOUNT_W'(count_r))))
    else $error("result missing or count mismatch");

  a_delete_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_func == OP_DELETE) && found) |=> (out_tuser == ST_DELETED))
    else $error("matching delete not reported");
`endif

endmodule

// ===== tb/slid_checker.sv =====
// Scoreboard for the sorted list block: watches both stream channels, keeps its own sorted
// list, predicts each result and compares it field by field with what the block returns.
// Depends on slid_pkg for the operation and status codes.
module slid_checker
  import slid_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // [15:0] value, [19:16] position, [23:20] zero
  input  logic [1:0]  in_tuser,   // [1:0] func
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // [15:0] read_value, [20:16] entry_count, [23:21] zero
  input  logic [2:0]  out_tuser,  // [2:0] status
  output int unsigned fail_count,
  output int unsigned pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [15:0]         read_value;
    logic [ECOUNT_W-1:0] entry_count;
  } list_result_t;

  // Shadow of the list contents, ascending, and the results still owed by the block
  logic signed [15:0] shadow_list [CAPACITY];
  int                 shadow_cnt;
  list_result_t       owed_q [$];
  int unsigned        errors;
  int unsigned        results_seen;

  // Apply one operation to the shadow list and return the result it should produce
  function automatic list_result_t apply_op(input logic [1:0] op,
                                            input logic signed [15:0] val,
                                            input logic [3:0] pos);
    list_result_t r;
    int at;
    r = '0;
    at = 0;
    case (op)
      OP_INSERT: begin
        if (shadow_cnt >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          // goes in front of the first entry that is not smaller
          while (at < shadow_cnt && shadow_list[at] < val) at++;
          for (int i = shadow_cnt; i > at; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[at] = val;
          shadow_cnt++;
          r.status = ST_INSERTED;
        end
      end
      OP_DELETE: begin
        if (shadow_cnt == 0) begin
          r.status = ST_EMPTY;
        end else begin
          while (at < shadow_cnt && shadow_list[at] != val) at++;
          if (at >= shadow_cnt) begin
            r.status = ST_NOT_FOUND;
          end else begin
            for (int i = at; i + 1 < shadow_cnt; i++) shadow_list[i] = shadow_list[i+1];
            shadow_cnt--;
            r.status = ST_DELETED;
          end
        end
      end
      OP_CLEAR: begin
        shadow_cnt = 0;
        r.status = ST_CLEARED;
      end
      default: begin
        if (int'(pos) < shadow_cnt) begin
          r.read_value = shadow_list[pos];
          r.status = ST_READ_OK;
        end else begin
          r.status = ST_RANGE;
        end
      end
    endcase
    r.entry_count = shadow_cnt[ECOUNT_W-1:0];
    return r;
  endfunction

  function automatic void note_mismatch(input string what, input int unsigned exp_v,
                                        input int unsigned act_v);
    errors++;
    if (errors <= 10)
      $display("%0t: result %0d %s mismatch: expected 0x%0h, got 0x%0h",
               $realtime, results_seen, what, exp_v, act_v);
  endfunction

  always @(posedge clk) begin
    list_result_t exp_r;
    if (!rst_n) begin
      owed_q.delete();
      shadow_cnt = 0;
      errors = 0;
      results_seen = 0;
    end else begin
      // results first: one accepted at this edge belongs to an earlier operation
      if (out_tvalid && out_tready) begin
        if (owed_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result transfer with nothing expected (status %0d, data 0x%0h)",
                     $realtime, out_tuser, out_tdata);
        end else begin
          exp_r = owed_q.pop_front();
          if (out_tuser !== exp_r.status)
            note_mismatch("status", exp_r.status, out_tuser);
          if (out_tdata[15:0] !== exp_r.read_value)
            note_mismatch("read_value", exp_r.read_value, out_tdata[15:0]);
          if (out_tdata[20:16] !== exp_r.entry_count)
            note_mismatch("entry_count", exp_r.entry_count, out_tdata[20:16]);
          if (out_tdata[23:21] !== 3'b000)
            note_mismatch("pad bits", 0, out_tdata[23:21]);
        end
        results_seen++;
      end
      if (in_tvalid && in_tready)
        owed_q.push_back(apply_op(in_tuser, in_tdata[15:0], in_tdata[19:16]));
    end
    fail_count <= errors;
    pending    <= owed_q.size();
  end

endmodule

// ===== tb/tb.sv =====
// Testbench top for sorted_list_insert_delete: clock, reset, operation stimulus with bursts
// and gaps, result-side stalls, and the final verdict. Depends on slid_pkg, the block and
// slid_checker.
module tb
  import slid_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAPACITY    = 16;
  localparam int unsigned N_RANDOM    = 550;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_AT     = 300;   // receiver cycle where the long hold starts
  localparam int unsigned HOLD_LEN    = 80;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [1:0]  in_tuser = OP_INSERT;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [2:0]  out_tuser;
  int unsigned fail_count;
  int unsigned pending;

  int unsigned burst_left = 1;
  int unsigned cycles = 0;

  sorted_list_insert_delete #(
    .CAPACITY   (CAPACITY),
    .VALUE_WIDTH(16)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  slid_checker #(.CAPACITY(CAPACITY)) checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("sorted_list_insert_delete test failed");
    $finish;
  end

  // Offer one operation and wait for its transfer; bursts end with a random gap
  task automatic send_op(input logic [1:0] op, input logic [15:0] val,
                         input logic [3:0] pos);
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0000, pos, val};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      // a zero gap keeps tvalid high into the next burst
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Result-side stalls: segments of always-ready, heavy, light and periodic back-pressure,
  // plus one long hold-off while the sender keeps offering
  initial begin
    int unsigned rx_cyc;
    int unsigned seg_len;
    int unsigned mode;
    bit          hold_done;
    rx_cyc = 0;
    hold_done = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      seg_len = $urandom_range(10, 60);
      repeat (seg_len) begin
        if (!hold_done && rx_cyc >= HOLD_AT) begin
          out_tready <= 1'b0;
          repeat (HOLD_LEN) @(posedge clk);
          rx_cyc += HOLD_LEN;
          hold_done = 1;
        end
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= ($urandom_range(0, 99) < 75);
          2:       out_tready <= ($urandom_range(0, 99) < 30);
          default: out_tready <= ((rx_cyc % 5) != 4);
        endcase
        @(posedge clk);
        rx_cyc++;
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int unsigned sent;
    int unsigned ep_len;
    int unsigned ep_kind;
    int unsigned roll;
    int unsigned ins_w;
    int unsigned del_w;
    logic [15:0] pool [6];
    logic [15:0] val;
    logic [1:0]  op;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-list cases, extremes, equal values, range limits
    send_op(OP_READ,   16'h0000, 4'd0);    // read of an empty list
    send_op(OP_DELETE, 16'h0005, 4'd0);    // delete when empty
    send_op(OP_CLEAR,  16'h0000, 4'd0);    // clear when already empty
    send_op(OP_INSERT, 16'h0000, 4'd0);
    send_op(OP_INSERT, 16'h8000, 4'd0);    // most negative
    send_op(OP_INSERT, 16'h7FFF, 4'd0);    // most positive
    send_op(OP_INSERT, 16'h0000, 4'd0);    // equal to a held entry
    send_op(OP_INSERT, 16'hFFFF, 4'd0);
    send_op(OP_INSERT, 16'h0001, 4'd0);
    send_op(OP_READ,   16'h0000, 4'd0);
    send_op(OP_READ,   16'h0000, 4'd5);
    send_op(OP_READ,   16'h0000, 4'd6);    // first position past the count
    send_op(OP_READ,   16'hFFFF, 4'd15);
    send_op(OP_DELETE, 16'h0000, 4'd0);    // one of two equal entries
    send_op(OP_DELETE, 16'h0002, 4'd0);    // no equal entry
    send_op(OP_DELETE, 16'h7FFF, 4'd0);
    send_op(OP_DELETE, 16'h8000, 4'd0);
    send_op(OP_CLEAR,  16'hFFFF, 4'd15);
    send_op(OP_READ,   16'h0000, 4'd0);
    send_op(OP_INSERT, 16'h5555, 4'd15);
    send_op(OP_INSERT, 16'hAAAA, 4'd10);
    send_op(OP_READ,   16'h0000, 4'd1);

    // Fill past capacity so inserts hit a full list
    sent = 0;
    repeat (CAPACITY + 3) begin
      send_op(OP_INSERT, 16'($urandom), 4'($urandom));
      sent++;
    end

    // Episodes of growth, shrinkage and mixed traffic over a small value pool
    while (sent < N_RANDOM) begin
      ep_len = $urandom_range(20, 60);
      ep_kind = $urandom_range(0, 2);
      ins_w = (ep_kind == 0) ? 70 : (ep_kind == 1) ? 15 : 35;
      del_w = (ep_kind == 0) ? 15 : (ep_kind == 1) ? 60 : 30;
      foreach (pool[i]) begin
        case ($urandom_range(0, 5))
          0:       pool[i] = 16'h8000;
          1:       pool[i] = 16'h7FFF;
          2:       pool[i] = 16'($urandom_range(0, 7)) - 16'd4;
          default: pool[i] = 16'($urandom);
        endcase
      end
      repeat (ep_len) begin
        roll = $urandom_range(0, 99);
        if (roll < 2)                  op = OP_CLEAR;
        else if (roll < 2 + ins_w)     op = OP_INSERT;
        else if (roll < 2 + ins_w + del_w) op = OP_DELETE;
        else                           op = OP_READ;
        val = ($urandom_range(0, 99) < 80) ? pool[$urandom_range(0, 5)] : 16'($urandom);
        send_op(op, val, 4'($urandom));
        sent++;
      end
    end

    // Drain and let any stray result surface
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("sorted_list_insert_delete test passed");
    end else begin
      $display("sorted_list_insert_delete test failed");
    end
    $finish;
  end

endmodule

// ===== sorted_list_insert_delete.f =====
hw/rtl/slid_pkg.sv
hw/rtl/slid_cell.sv
hw/rtl/sorted_list_insert_delete.sv
tb/slid_checker.sv
tb/tb.sv
